// ----- sv/tefa_pkg.sv -----
`default_nettype none

package tefa_pkg;

    // Event types and codes, standard input-subsystem numbering.
    localparam logic [4:0]  TYPE_SYNC        = 5'd0;
    localparam logic [4:0]  TYPE_KEY         = 5'd1;
    localparam logic [4:0]  TYPE_ABS         = 5'd3;
    localparam logic [15:0] SYNC_FRAME       = 16'h0000;
    localparam logic [15:0] SYNC_CONTACT     = 16'h0002;
    localparam logic [15:0] KEY_TOUCH        = 16'h014A;
    localparam logic [15:0] AXIS_PRESSURE    = 16'h0018;
    localparam logic [15:0] AXIS_SLOT        = 16'h002F;
    localparam logic [15:0] AXIS_MAJOR       = 16'h0030;
    localparam logic [15:0] AXIS_POS_X       = 16'h0035;
    localparam logic [15:0] AXIS_POS_Y       = 16'h0036;
    localparam logic [15:0] AXIS_TRACK       = 16'h0039;
    localparam logic [15:0] AXIS_MT_PRESSURE = 16'h003A;

    // Register map: the index is address bit 2.
    localparam logic REG_ENABLE = 1'b0;
    localparam logic REG_X_SPAN = 1'b1;

    localparam logic        ENABLE_RESET = 1'b1;
    localparam logic [15:0] X_SPAN_RESET = 16'd440;

    // Timestamp conversion: usec / 1000 as a reciprocal multiply, exact below 2^20.
    localparam int MS_PER_SEC  = 1000;
    localparam int USEC_RECIP  = 1073742;
    localparam int RECIP_SHIFT = 30;

    // Queue between the classifier and the slot store.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Operations that the back end carries out on the slot store.
    typedef enum logic [2:0] {
        OP_PRESS_FILL,
        OP_PRESS,
        OP_FILL,
        OP_SLOT,
        OP_POS_X,
        OP_POS_Y,
        OP_CONTACT,
        OP_FRAME
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] value;
        logic [31:0] ms;
    } item_t;

    typedef struct packed {
        logic        enable;
        logic [15:0] x_span;
    } cfg_t;

endpackage

`default_nettype wire

// ----- sv/tefa_front.sv -----
`default_nettype none

module tefa_front #(
    parameter int MAX_SLOTS = 1
) (
    input  wire logic           in_valid,
    input  wire logic           in_ready,
    input  wire logic [4:0]     event_type,
    input  wire logic [15:0]    event_code,
    input  wire logic [31:0]    event_value,
    input  wire logic [31:0]    time_sec,
    input  wire logic [19:0]    time_usec,
    output tefa_pkg::item_t     push_item,
    output logic                push
);

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    logic [41:0]       sec_prod;
    logic [40:0]       usec_prod;
    logic [10:0]       usec_ms;
    logic [31:0]       ms_val;
    logic              val_neg;
    logic [SLOT_W-1:0] slot_idx;
    logic              use_event;

    // Timestamp in milliseconds, wrapping at 32 bits.
    assign sec_prod  = {10'd0, time_sec} * 42'(tefa_pkg::MS_PER_SEC);
    assign usec_prod = {21'd0, time_usec} * 41'(tefa_pkg::USEC_RECIP);
    assign usec_ms   = usec_prod[tefa_pkg::RECIP_SHIFT +: 11];
    assign ms_val    = sec_prod[31:0] + {21'd0, usec_ms};

    // A non-negative slot number outside the store selects slot zero; a negative one is dropped.
    assign val_neg  = event_value[31];
    assign slot_idx = (event_value < 32'(MAX_SLOTS)) ? event_value[SLOT_W-1:0] : '0;

    // Classify the event into one store operation, or drop it.
    always_comb
    begin
        use_event       = 1'b0;
        push_item.op    = tefa_pkg::OP_FILL;
        push_item.value = event_value;
        push_item.ms    = ms_val;
        unique case (event_type)
            tefa_pkg::TYPE_KEY:
            begin
                if (event_code == tefa_pkg::KEY_TOUCH)
                begin
                    use_event    = 1'b1;
                    push_item.op = tefa_pkg::OP_PRESS_FILL;
                end
            end
            tefa_pkg::TYPE_ABS:
            begin
                unique case (event_code)
                    tefa_pkg::AXIS_PRESSURE, tefa_pkg::AXIS_MT_PRESSURE:
                    begin
                        use_event    = 1'b1;
                        push_item.op = tefa_pkg::OP_PRESS;
                    end
                    tefa_pkg::AXIS_SLOT:
                    begin
                        use_event       = !val_neg;
                        push_item.op    = tefa_pkg::OP_SLOT;
                        push_item.value = 32'(slot_idx);
                    end
                    tefa_pkg::AXIS_MAJOR:
                    begin
                        // A zero major axis clears the pressure as well.
                        use_event = 1'b1;
                        if (event_value == 32'd0)
                        begin
                            push_item.op = tefa_pkg::OP_PRESS_FILL;
                        end
                        else
                        begin
                            push_item.op = tefa_pkg::OP_FILL;
                        end
                    end
                    tefa_pkg::AXIS_POS_X:
                    begin
                        use_event    = 1'b1;
                        push_item.op = tefa_pkg::OP_POS_X;
                    end
                    tefa_pkg::AXIS_POS_Y:
                    begin
                        use_event    = 1'b1;
                        push_item.op = tefa_pkg::OP_POS_Y;
                    end
                    tefa_pkg::AXIS_TRACK:
                    begin
                        // A released tracking id lifts the contact.
                        use_event       = (event_value == 32'hFFFF_FFFF);
                        push_item.op    = tefa_pkg::OP_PRESS_FILL;
                        push_item.value = 32'd0;
                    end
                    default:
                    begin
                        use_event = 1'b0;
                    end
                endcase
            end
            tefa_pkg::TYPE_SYNC:
            begin
                if (event_code == tefa_pkg::SYNC_CONTACT)
                begin
                    use_event    = 1'b1;
                    push_item.op = tefa_pkg::OP_CONTACT;
                end
                else if (event_code == tefa_pkg::SYNC_FRAME)
                begin
                    use_event    = 1'b1;
                    push_item.op = tefa_pkg::OP_FRAME;
                end
            end
            default:
            begin
                use_event = 1'b0;
            end
        endcase
    end

    assign push = in_valid && in_ready && use_event;

endmodule

`default_nettype wire

// ----- sv/tefa_queue.sv -----
`default_nettype none

module tefa_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire tefa_pkg::item_t  push_item,
    output logic                  full,
    input  wire logic             pop,
    output tefa_pkg::item_t       pop_item,
    output logic                  valid
);

    localparam int PW = tefa_pkg::QUEUE_PTR_W;
    localparam int CW = tefa_pkg::QUEUE_CNT_W;
    localparam logic [PW-1:0] LAST_PTR = PW'(tefa_pkg::QUEUE_DEPTH - 1);

    tefa_pkg::item_t store_reg [tefa_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full     = (count_reg == CW'(tefa_pkg::QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_item = store_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- sv/tefa_back.sv -----
`default_nettype none

module tefa_back #(
    parameter int MAX_SLOTS = 1
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire tefa_pkg::cfg_t   cfg,
    input  wire logic             q_valid,
    input  wire tefa_pkg::item_t  q_item,
    output logic                  q_pop,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  out_found,
    output logic [3:0]            out_id,
    output logic [31:0]           out_pressure,
    output logic [31:0]           out_x,
    output logic [31:0]           out_y,
    output logic [31:0]           out_ms
);

    localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

    logic [31:0]          x_reg [MAX_SLOTS];
    logic [31:0]          y_reg [MAX_SLOTS];
    logic [31:0]          p_reg [MAX_SLOTS];
    logic [31:0]          x_next [MAX_SLOTS];
    logic [31:0]          y_next [MAX_SLOTS];
    logic [31:0]          p_next [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] filled_reg, filled_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [1:0]           count_reg, count_next;
    logic                 pen_reg, pen_next;

    logic [MAX_SLOTS-1:0] eff_filled;
    logic                 found;
    logic [SLOT_W-1:0]    found_id;
    logic                 found_lifted;
    logic [31:0]          sel_x, sel_y, sel_p, sel_ms;
    logic                 is_frame;
    logic                 load_out;

    logic                 out_valid_reg, out_valid_next;
    logic                 found_reg;
    logic [3:0]           id_reg;
    logic [31:0]          pressure_reg, x_out_reg, y_out_reg, ms_reg;

    // A frame word needs room in the output register; others retire at once.
    assign is_frame = (q_item.op == tefa_pkg::OP_FRAME);
    assign q_pop    = q_valid && (!is_frame || !out_valid_reg || out_ready);
    assign load_out = q_pop && is_frame;

    // Lowest filled slot, counting the current slot as filled when the pen lifted.
    always_comb
    begin
        found    = 1'b0;
        found_id = '0;
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            eff_filled[i] = filled_reg[i] || (pen_reg && (slot_reg == SLOT_W'(i)));
        end
        for (int i = MAX_SLOTS - 1; i >= 0; i--)
        begin
            if (eff_filled[i])
            begin
                found    = 1'b1;
                found_id = SLOT_W'(i);
            end
        end
    end

    // Sample read-out; a lifted pen reads as zeros.
    assign found_lifted = pen_reg && (found_id == slot_reg);
    assign sel_x  = (found && !found_lifted) ? x_reg[found_id] : 32'd0;
    assign sel_y  = (found && !found_lifted) ? y_reg[found_id] : 32'd0;
    assign sel_p  = (found && !found_lifted) ? p_reg[found_id] : 32'd0;
    assign sel_ms = found ? q_item.ms : 32'd0;

    // Store update for the word at the head of the queue.
    always_comb
    begin
        x_next      = x_reg;
        y_next      = y_reg;
        p_next      = p_reg;
        filled_next = filled_reg;
        slot_next   = slot_reg;
        count_next  = count_reg;
        pen_next    = pen_reg;
        if (q_pop)
        begin
            unique case (q_item.op)
                tefa_pkg::OP_PRESS_FILL:
                begin
                    p_next[slot_reg]      = q_item.value;
                    filled_next[slot_reg] = 1'b1;
                end
                tefa_pkg::OP_PRESS:
                begin
                    p_next[slot_reg] = q_item.value;
                end
                tefa_pkg::OP_FILL:
                begin
                    filled_next[slot_reg] = 1'b1;
                end
                tefa_pkg::OP_SLOT:
                begin
                    slot_next = q_item.value[SLOT_W-1:0];
                end
                tefa_pkg::OP_POS_X, tefa_pkg::OP_POS_Y:
                begin
                    if (count_reg < 2'd2)
                    begin
                        count_next = count_reg + 2'd1;
                    end
                    if (q_item.op == tefa_pkg::OP_POS_X)
                    begin
                        x_next[slot_reg] = q_item.value;
                    end
                    else
                    begin
                        y_next[slot_reg] = q_item.value;
                    end
                    filled_next[slot_reg] = 1'b1;
                end
                tefa_pkg::OP_CONTACT:
                begin
                    if (count_reg == 2'd1)
                    begin
                        pen_next = 1'b1;
                    end
                    else if (count_reg >= 2'd2)
                    begin
                        count_next = 2'd1;
                    end
                end
                tefa_pkg::OP_FRAME:
                begin
                    if (pen_reg)
                    begin
                        x_next[slot_reg] = 32'd0;
                        y_next[slot_reg] = 32'd0;
                        p_next[slot_reg] = 32'd0;
                    end
                    filled_next = '0;
                    count_next  = 2'd0;
                    pen_next    = 1'b0;
                end
                default:
                begin
                    filled_next = filled_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SLOTS; i++)
            begin
                x_reg[i] <= 32'd0;
                y_reg[i] <= 32'd0;
                p_reg[i] <= 32'd0;
            end
            filled_reg <= '0;
            slot_reg   <= '0;
            count_reg  <= 2'd0;
            pen_reg    <= 1'b0;
        end
        else
        begin
            x_reg      <= x_next;
            y_reg      <= y_next;
            p_reg      <= p_next;
            filled_reg <= filled_next;
            slot_reg   <= slot_next;
            count_reg  <= count_next;
            pen_reg    <= pen_next;
        end
    end

    // Output register: holds a result word until the receiver takes it.
    assign out_valid_next = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            found_reg <= found;
            if (cfg.enable)
            begin
                id_reg       <= 4'(found_id);
                pressure_reg <= sel_p;
                x_out_reg    <= {16'd0, cfg.x_span} - sel_y;
                y_out_reg    <= sel_x;
                ms_reg       <= sel_ms;
            end
            else
            begin
                id_reg       <= 4'd0;
                pressure_reg <= 32'd0;
                x_out_reg    <= 32'd0;
                y_out_reg    <= 32'd0;
                ms_reg       <= 32'd0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_found    = found_reg;
    assign out_id       = id_reg;
    assign out_pressure = pressure_reg;
    assign out_x        = x_out_reg;
    assign out_y        = y_out_reg;
    assign out_ms       = ms_reg;

`ifndef SYNTHESIS
    // A frame word leaves no filled slot and no pending contact state behind.
    a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (filled_reg == '0) && (count_reg == 2'd0) && !pen_reg)
        else $error("frame did not clear the per-frame state");

    // The position count saturates at two.
    a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("position count overflow");

    // The current slot always lies inside the store.
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(slot_reg) < 32'(MAX_SLOTS))
        else $error("current slot out of range");

    // A frame word is never retired while a result waits unaccepted.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !load_out)
        else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

// ----- sv/touch_event_frame_assembler_core.sv -----
// Touch event frame assembler.
// Input stream (s_*): one input-subsystem event per word, event type in tuser,
// code, value and timestamp in tdata. Events that update nothing are accepted
// and dropped. Output stream (m_*): one word per frame sync event, carrying
// the lowest filled slot with rotated coordinates and a millisecond timestamp;
// sample_found travels in tuser.
// Configuration: APB port, enable at address 0, x_span at address 4; write it
// only while the stream is idle.
// Throughput: one event per cycle while the queue has room. The classifier and
// a two-word queue take a word per cycle, and the slot store retires one word
// per cycle from the queue unless a frame word waits for the output register.
// A frame sync event accepted on the input is written into the queue, then
// popped and loaded into the output register, which drives m_tvalid.
// When the receiver stalls, the result holds in the output register and
// non-reporting events keep flowing until a further frame sync event reaches
// the head of the queue and waits there; s_tready drops once the queue is full.
// Reset clears the slot store, the frame state and the queue, and sets enable
// to one and x_span to 440.
`default_nettype none

module touch_event_frame_assembler_core #(
    parameter int MAX_SLOTS = 1
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    // Event input.
    input  wire logic           s_tvalid,
    output logic                s_tready,
    // s_tdata: event_code[15:0], event_value[47:16], time_sec[79:48],
    // time_usec[99:80], zero fill [103:100].
    input  wire logic [103:0]   s_tdata,
    // s_tuser: event_type[4:0].
    input  wire logic [4:0]     s_tuser,
    // Sample output.
    output logic                m_tvalid,
    input  wire logic           m_tready,
    // m_tdata: touch_id[3:0], touch_pressure[35:4], touch_x[67:36],
    // touch_y[99:68], time_ms[131:100], zero fill [135:132].
    output logic [135:0]        m_tdata,
    // m_tuser: sample_found[0].
    output logic [0:0]          m_tuser,
    // Configuration port.
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [2:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    tefa_pkg::cfg_t  cfg_reg;
    tefa_pkg::item_t push_item;
    tefa_pkg::item_t pop_item;
    logic            push;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;
    logic            out_found;
    logic [3:0]      out_id;
    logic [31:0]     out_pressure;
    logic [31:0]     out_x;
    logic [31:0]     out_y;
    logic [31:0]     out_ms;

    // Configuration registers.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable <= tefa_pkg::ENABLE_RESET;
            cfg_reg.x_span <= tefa_pkg::X_SPAN_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == tefa_pkg::REG_ENABLE)
            begin
                cfg_reg.enable <= pwdata[0];
            end
            else
            begin
                cfg_reg.x_span <= pwdata[15:0];
            end
        end
    end

    assign prdata = (paddr[2] == tefa_pkg::REG_X_SPAN) ? {16'd0, cfg_reg.x_span}
                                                       : {31'd0, cfg_reg.enable};

    // Front end: accept and classify events.
    assign s_tready = !q_full;

    tefa_front #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_front (
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .event_type  (s_tuser),
        .event_code  (s_tdata[15:0]),
        .event_value (s_tdata[47:16]),
        .time_sec    (s_tdata[79:48]),
        .time_usec   (s_tdata[99:80]),
        .push_item   (push_item),
        .push        (push)
    );

    tefa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .valid     (q_valid)
    );

    // Back end: slot store and result register.
    tefa_back #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_item       (pop_item),
        .q_pop        (q_pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_found    (out_found),
        .out_id       (out_id),
        .out_pressure (out_pressure),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_ms       (out_ms)
    );

    assign m_tdata = {4'd0, out_ms, out_y, out_x, out_pressure, out_id};
    assign m_tuser = out_found;

endmodule

`default_nettype wire

// ----- tb/touch_event_frame_assembler_core_tb.sv -----
`timescale 1ns / 100ps

module touch_event_frame_assembler_core_tb;

    localparam int NUM_SLOTS     = 1;
    localparam int RANDOM_EVENTS = 820;
    localparam int RANDOM_PHASES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTED  = 10;

    // Codes that the block does not know and must ignore.
    localparam logic [4:0]  TYPE_UNUSED = 5'd31;
    localparam logic [15:0] AXIS_UNUSED = 16'h0001;
    localparam logic [15:0] SYNC_UNUSED = 16'h0001;
    // Tracking id -1 marks a lifted contact.
    localparam logic [31:0] TRACK_NONE  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        found;
        logic [3:0]  id;
        logic [31:0] pressure;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] ms;
    } sample_t;

    logic           clk;
    logic           rst_n;
    logic           s_tvalid;
    logic           s_tready;
    logic [103:0]   s_tdata;
    logic [4:0]     s_tuser;
    logic           m_tvalid;
    logic           m_tready;
    logic [135:0]   m_tdata;
    logic [0:0]     m_tuser;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [2:0]     paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;

    // Frame state as the block should hold it.
    logic           cfg_enable;
    logic [15:0]    cfg_x_span;
    logic [31:0]    contact_x [NUM_SLOTS];
    logic [31:0]    contact_y [NUM_SLOTS];
    logic [31:0]    contact_pressure [NUM_SLOTS];
    logic           contact_filled [NUM_SLOTS];
    int unsigned    active_slot;
    logic [1:0]     axis_count;
    logic           pen_up;

    sample_t        expected_samples [$];
    int             mismatch_count = 0;
    int             cycle_count = 0;
    bit             tx_idle_on = 1'b1;
    bit             rx_idle_on = 1'b1;
    bit             hold_request = 1'b0;

    touch_event_frame_assembler_core #(
        .MAX_SLOTS(NUM_SLOTS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Apply one accepted event to the frame state and queue the sample it reports.
    task automatic predict_event(input logic [4:0] ev_type, input logic [15:0] ev_code,
                                 input logic [31:0] ev_value, input logic [31:0] sec,
                                 input logic [19:0] usec);
        int unsigned s;
        int          i;
        bit          found;
        logic [3:0]  id;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pp;
        logic [31:0] ms;
        sample_t     smp;
        s = (active_slot < NUM_SLOTS) ? active_slot : 0;
        if (ev_type == tefa_pkg::TYPE_KEY)
        begin
            if (ev_code == tefa_pkg::KEY_TOUCH)
            begin
                contact_pressure[s] = ev_value;
                contact_filled[s] = 1'b1;
            end
        end
        else if (ev_type == tefa_pkg::TYPE_ABS)
        begin
            case (ev_code)
                tefa_pkg::AXIS_PRESSURE, tefa_pkg::AXIS_MT_PRESSURE:
                    contact_pressure[s] = ev_value;
                tefa_pkg::AXIS_SLOT:
                    if (!ev_value[31])
                        active_slot = (ev_value < NUM_SLOTS) ? ev_value : 0;
                tefa_pkg::AXIS_MAJOR:
                begin
                    if (ev_value == 32'h0)
                        contact_pressure[s] = 32'h0;
                    contact_filled[s] = 1'b1;
                end
                tefa_pkg::AXIS_POS_X, tefa_pkg::AXIS_POS_Y:
                begin
                    if (axis_count < 2'd2)
                        axis_count = axis_count + 2'd1;
                    if (ev_code == tefa_pkg::AXIS_POS_X)
                        contact_x[s] = ev_value;
                    else
                        contact_y[s] = ev_value;
                    contact_filled[s] = 1'b1;
                end
                tefa_pkg::AXIS_TRACK:
                    if (ev_value == TRACK_NONE)
                    begin
                        contact_pressure[s] = 32'h0;
                        contact_filled[s] = 1'b1;
                    end
                default:
                    ;
            endcase
        end
        else if (ev_type == tefa_pkg::TYPE_SYNC && ev_code == tefa_pkg::SYNC_CONTACT)
        begin
            // One position since the last contact report means the pen went up.
            if (axis_count == 2'd1)
                pen_up = 1'b1;
            else if (axis_count >= 2'd2)
                axis_count = 2'd1;
        end
        else if (ev_type == tefa_pkg::TYPE_SYNC && ev_code == tefa_pkg::SYNC_FRAME)
        begin
            if (pen_up)
            begin
                contact_x[s] = 32'h0;
                contact_y[s] = 32'h0;
                contact_pressure[s] = 32'h0;
                contact_filled[s] = 1'b1;
            end
            // The lowest filled slot is reported; all marks are cleared.
            found = 1'b0;
            id = 4'h0;
            px = 32'h0;
            py = 32'h0;
            pp = 32'h0;
            ms = 32'h0;
            for (i = 0; i < NUM_SLOTS; i++)
            begin
                if (contact_filled[i] && !found)
                begin
                    found = 1'b1;
                    id = 4'(i);
                    px = contact_x[i];
                    py = contact_y[i];
                    pp = contact_pressure[i];
                    ms = sec * tefa_pkg::MS_PER_SEC + 32'(usec) / tefa_pkg::MS_PER_SEC;
                end
                contact_filled[i] = 1'b0;
            end
            axis_count = 2'd0;
            pen_up = 1'b0;
            smp = '0;
            smp.found = found;
            if (cfg_enable)
            begin
                smp.id = id;
                smp.pressure = pp;
                smp.x = {16'h0, cfg_x_span} - py;
                smp.y = px;
                smp.ms = ms;
            end
            expected_samples.push_back(smp);
        end
    endtask

    // Offer one event word after a random gap and wait until it is taken.
    task automatic send_event(input logic [4:0] ev_type, input logic [15:0] ev_code,
                              input logic [31:0] ev_value, input logic [31:0] sec,
                              input logic [19:0] usec);
        int unsigned gap;
        gap = tx_idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'h0, usec, sec, ev_value, ev_code};
        s_tuser  <= ev_type;
        do
        begin
            @(posedge clk);
        end
        while (s_tready !== 1'b1);
        predict_event(ev_type, ev_code, ev_value, sec, usec);
    endtask

    // Event with a random timestamp over the full field widths.
    task automatic post(input logic [4:0] ev_type, input logic [15:0] ev_code,
                        input logic [31:0] ev_value);
        send_event(ev_type, ev_code, ev_value, $urandom, 20'($urandom_range(0, 1048575)));
    endtask

    // Stop offering words and wait until every sample is back and the pipe is empty.
    task automatic drain_samples();
        s_tvalid <= 1'b0;
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup phase and access phase, then the bus idles before the next transfer.
    task automatic write_register(input logic reg_index, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_index == tefa_pkg::REG_ENABLE)
            cfg_enable = data[0];
        else
            cfg_x_span = data[15:0];
        @(posedge clk);
    endtask

    // Upper write data bits are random; the registers keep only their own width.
    task automatic apply_settings(input logic en, input logic [15:0] span);
        logic [31:0] en_word;
        logic [31:0] span_word;
        en_word = $urandom;
        span_word = $urandom;
        en_word[0] = en;
        span_word[15:0] = span;
        drain_samples();
        write_register(tefa_pkg::REG_ENABLE, en_word);
        write_register(tefa_pkg::REG_X_SPAN, span_word);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h0;
            1:       return TRACK_NONE;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4, 5:    return $urandom_range(0, 1023);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_slot();
        case ($urandom_range(0, 4))
            0:       return TRACK_NONE;
            1:       return 32'h0;
            2:       return 32'(NUM_SLOTS);
            3:       return 32'd15;
            default: return $urandom;
        endcase
    endfunction

    // A frame of random updates, mostly closed by a report, with some noise.
    task automatic send_random_frame(output int unsigned sent);
        int unsigned n;
        sent = 0;
        n = $urandom_range(1, 6);
        repeat (n)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                post(5'($urandom_range(0, 31)), 16'($urandom_range(0, 65535)), $urandom);
                sent++;
            end
            case ($urandom_range(0, 9))
                0:       post(tefa_pkg::TYPE_ABS, tefa_pkg::AXIS_SLOT, pick_slot());
                1, 2:    post(tefa_pkg::TYPE_ABS, tefa_pkg::AXIS_POS_X, pick_value());
                3, 4:    post(tefa_pkg::TYPE_ABS, tefa_pkg::AXIS_POS_Y, pick_value());
                5:       post(tefa_pkg::TYPE_ABS,
                              $urandom_range(0, 1) ? tefa_pkg::AXIS_PRESSURE
                                                   : tefa_pkg::AXIS_MT_PRESSURE,
                              pick_value());
                6:       post(tefa_pkg::TYPE_KEY, tefa_pkg::KEY_TOUCH, pick_value());
                7:       post(tefa_pkg::TYPE_ABS, tefa_pkg::AXIS_MAJOR,
                              $urandom_range(0, 1) ? 32'h0 : pick_value());
                8:       post(tefa_pkg::TYPE_ABS, tefa_pkg::AXIS_TRACK,
                              $urandom_range(0, 1) ? TRACK_NONE : pick_value());
                default: post(tefa_pkg::TYPE_SYNC, tefa_pkg::SYNC_CONTACT, pick_value());
            endcase
            sent++;
        end
        if ($urandom_range(0, 7) != 0)
        begin
            post(tefa_pkg::TYPE_SYNC, tefa_pkg::SYNC_FRAME, pick_value());
            sent++;
        end
    endtask

    task automatic test_directed_events();
        // Empty frame: only x_span shows.
        post(tefa_pkg::TYPE_SYNC, tefa_pkg::SYNC_FRAME, 32'h0);
        // Coordinate extremes and the largest timestamp.
        post(tefa_pkg::TYPE_ABS, tefa_pkg::AXIS_POS_X, 32'h7FFF_FFFF);
        post(tefa_pkg::TYPE_ABS, tefa_pkg::AXIS_POS_Y, 32'h8000_0000);
        post(tefa_pkg::TYPE_ABS, tefa_pkg::AXIS_PRESSURE, 32'hFFFF_FFFF);
        send_event(tefa_pkg::TYPE_SYNC, tefa_pkg::SYNC_FRAME, 32'h0, 32'hFFFF_FFFF, 20'hFFFFF);
        // Touch key fills the slot.
        post(tefa_pkg::TYPE_KEY, tefa_pkg::KEY_TOUCH, 32'h1);
        send_event(tefa_pkg::TYPE_SYNC, tefa_pkg::SYNC_FRAME, 32'h0, 32'h0, 20'd999999);
        // Touch major of zero clears pressure; nonzero only fills.
        post(tefa_pkg::TYPE_ABS, tefa_pkg::AXIS_MAJOR, 32'h0);
        post(tefa_pkg::TYPE_ABS, tefa_pkg::AXIS_MT_PRESSURE, 32'd55);
        post(tefa_pkg::TYPE_ABS, tefa_pkg::AXIS_MAJOR, 32'd9);
        post(tefa_pkg::TYPE_SYNC, tefa_pkg::SYNC_FRAME, 32'h0);
        // Tracking id -1 lifts the contact; slot events with negative and large values.
        post(tefa_pkg::TYPE_ABS, tefa_pkg::AXIS_TRACK, TRACK_NONE);
        post(tefa_pkg::TYPE_ABS, tefa_pkg::AXIS_TRACK, 32'd5);
        post(tefa_pkg::TYPE_ABS, tefa_pkg::AXIS_SLOT, 32'h8000_0000);
        post(tefa_pkg::TYPE_ABS, tefa_pkg::AXIS_SLOT, 32'd7);
        post(tefa_pkg::TYPE_ABS, tefa_pkg::AXIS_SLOT, 32'h0);
        post(tefa_pkg::TYPE_SYNC, tefa_pkg::SYNC_FRAME, 32'h0);
        // Contact report with no, one and two positions.
        post(tefa_pkg::TYPE_SYNC, tefa_pkg::SYNC_CONTACT, 32'h0);
        post(tefa_pkg::TYPE_ABS, tefa_pkg::AXIS_POS_X, 32'd100);
        post(tefa_pkg::TYPE_SYNC, tefa_pkg::SYNC_CONTACT, 32'h0);
        post(tefa_pkg::TYPE_SYNC, tefa_pkg::SYNC_FRAME, 32'h0);
        post(tefa_pkg::TYPE_ABS, tefa_pkg::AXIS_POS_X, 32'd12);
        post(tefa_pkg::TYPE_ABS, tefa_pkg::AXIS_POS_Y, 32'd34);
        post(tefa_pkg::TYPE_SYNC, tefa_pkg::SYNC_CONTACT, 32'h0);
        post(tefa_pkg::TYPE_SYNC, tefa_pkg::SYNC_CONTACT, 32'h0);
        post(tefa_pkg::TYPE_SYNC, tefa_pkg::SYNC_FRAME, 32'h0);
        // Unknown types and codes change nothing.
        post(TYPE_UNUSED, tefa_pkg::KEY_TOUCH, 32'd3);
        post(tefa_pkg::TYPE_ABS, AXIS_UNUSED, 32'd4);
        post(tefa_pkg::TYPE_SYNC, SYNC_UNUSED, 32'h0);
        post(tefa_pkg::TYPE_SYNC, tefa_pkg::SYNC_FRAME, 32'h0);
    endtask

    task automatic test_register_settings();
        // Disabled output zeroes all but the found flag.
        apply_settings(1'b0, tefa_pkg::X_SPAN_RESET);
        post(tefa_pkg::TYPE_ABS, tefa_pkg::AXIS_POS_X, 32'd5);
        post(tefa_pkg::TYPE_ABS, tefa_pkg::AXIS_POS_Y, 32'd6);
        post(tefa_pkg::TYPE_ABS, tefa_pkg::AXIS_PRESSURE, 32'd7);
        post(tefa_pkg::TYPE_SYNC, tefa_pkg::SYNC_FRAME, 32'h0);
        post(tefa_pkg::TYPE_SYNC, tefa_pkg::SYNC_FRAME, 32'h0);
        // Smallest and largest span, with wrap of the rotated X.
        apply_settings(1'b1, 16'h0000);
        post(tefa_pkg::TYPE_ABS, tefa_pkg::AXIS_POS_Y, 32'd1);
        post(tefa_pkg::TYPE_SYNC, tefa_pkg::SYNC_FRAME, 32'h0);
        apply_settings(1'b1, 16'hFFFF);
        post(tefa_pkg::TYPE_ABS, tefa_pkg::AXIS_POS_Y, 32'h8000_0000);
        post(tefa_pkg::TYPE_SYNC, tefa_pkg::SYNC_FRAME, 32'h0);
        post(tefa_pkg::TYPE_SYNC, tefa_pkg::SYNC_FRAME, 32'h0);
        apply_settings(1'b1, tefa_pkg::X_SPAN_RESET);
    endtask

    // The receiver holds off while frames keep coming, so the input must stall.
    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_request = 1'b1;
        repeat (12)
        begin
            post(tefa_pkg::TYPE_ABS, tefa_pkg::AXIS_POS_X, pick_value());
            post(tefa_pkg::TYPE_ABS, tefa_pkg::AXIS_POS_Y, pick_value());
            post(tefa_pkg::TYPE_SYNC, tefa_pkg::SYNC_FRAME, 32'h0);
        end
        drain_samples();
    endtask

    task automatic test_random_frames();
        int unsigned useful;
        int unsigned sent;
        int unsigned phase;
        logic [15:0] span;
        useful = 0;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(0, 3))
                0:       span = 16'h0000;
                1:       span = 16'hFFFF;
                2:       span = tefa_pkg::X_SPAN_RESET;
                default: span = 16'($urandom);
            endcase
            apply_settings($urandom_range(0, 3) != 0, span);
            tx_idle_on = (phase % 4 == 0) || (phase % 4 == 1);
            rx_idle_on = (phase % 4 == 0) || (phase % 4 == 2);
            while (useful < (phase + 1) * (RANDOM_EVENTS / RANDOM_PHASES))
            begin
                send_random_frame(sent);
                useful += sent;
            end
        end
    endtask

    // Sample receiver: random ready gaps, plus one long hold on request.
    initial
    begin : sample_receiver
        int unsigned gap;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = rx_idle_on ? $urandom_range(0, 9) : 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (m_tvalid !== 1'b1 && !hold_request);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
        end
    end

    // Compare every sample word taken from the block with the oldest expected one.
    always @(posedge clk)
    begin : sample_check
        sample_t got;
        sample_t want;
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            got = {m_tuser[0], m_tdata[3:0], m_tdata[35:4], m_tdata[67:36],
                   m_tdata[99:68], m_tdata[131:100]};
            if (expected_samples.size() == 0)
            begin
                if (mismatch_count < MAX_REPORTED)
                    $display("Unexpected sample: found=%0d id=%0d p=%h x=%h y=%h ms=%h",
                             got.found, got.id, got.pressure, got.x, got.y, got.ms);
                mismatch_count++;
            end
            else
            begin
                want = expected_samples.pop_front();
                if (got !== want)
                begin
                    if (mismatch_count < MAX_REPORTED)
                    begin
                        $display("Sample mismatch at %0t:", $realtime);
                        $display("  expected found=%0d id=%0d p=%h x=%h y=%h ms=%h",
                                 want.found, want.id, want.pressure, want.x, want.y, want.ms);
                        $display("  actual   found=%0d id=%0d p=%h x=%h y=%h ms=%h",
                                 got.found, got.id, got.pressure, got.x, got.y, got.ms);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin : test_sequence
        int i;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        rst_n    <= 1'b0;
        // Frame state after reset.
        cfg_enable = tefa_pkg::ENABLE_RESET;
        cfg_x_span = tefa_pkg::X_SPAN_RESET;
        for (i = 0; i < NUM_SLOTS; i++)
        begin
            contact_x[i] = 32'h0;
            contact_y[i] = 32'h0;
            contact_pressure[i] = 32'h0;
            contact_filled[i] = 1'b0;
        end
        active_slot = 0;
        axis_count = 2'd0;
        pen_up = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_events();
        test_register_settings();
        test_backpressure();
        test_random_frames();
        drain_samples();
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
